FILE: design/hwag_pkg.sv
// shared types and constants for the half-wave arch gate
package hwag_pkg;

  // default arch buffer depth
  localparam int MAX_ARCH_DEF = 64;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = 17;
  localparam int LEN_W     = 7;
  localparam int SUM_W     = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 22;

  // register reset values
  localparam logic [LEN_W-1:0] WIDTH_MIN_RST = 7'd4;
  localparam logic [LEN_W-1:0] WIDTH_MAX_RST = 7'd65;
  localparam logic [SUM_W-1:0] POWER_THR_RST = 22'd128;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_MIN = 2'd0,
    REG_WIDTH_MAX = 2'd1,
    REG_POWER_THR = 2'd2
  } cfg_reg_t;

  // one finished arch handed from front to back
  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             keep;
  } desc_t;

endpackage

FILE: design/hwag_ram.sv
// generic simple dual-port ram with registered read
module hwag_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/hwag_front.sv
// front end: accepts samples, tracks arches, gates them and writes the buffer
module hwag_front #(
  parameter int MAX_ARCH = hwag_pkg::MAX_ARCH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hwag_pkg::SAMPLE_W-1:0]   sample_in,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hwag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hwag_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            bank_free,
  output logic                            wr_en,
  output logic [$clog2(MAX_ARCH):0]       wr_addr,
  output logic [hwag_pkg::SAMPLE_W-1:0]   wr_data,
  output logic                            push,
  output hwag_pkg::desc_t                 push_desc
);

  import hwag_pkg::*;

  localparam int IDX_W = $clog2(MAX_ARCH);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ARCH);

  logic [LEN_W-1:0] width_min;
  logic [LEN_W-1:0] width_max;
  logic [SUM_W-1:0] power_thr;

  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] len_next;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic             pol_up;
  logic             bank;

  logic             neg;
  logic             pos;
  logic [MAG_W-1:0] sx;
  logic [MAG_W-1:0] mag;
  logic             flip;
  logic             emit;
  logic             take;
  logic             keep;
  logic             wr_bank;
  logic [LEN_W-1:0] base_len;
  logic [SUM_W-1:0] base_sum;
  logic [SUM_W:0]   sum_wide;
  logic             room;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_min <= WIDTH_MIN_RST;
      width_max <= WIDTH_MAX_RST;
      power_thr <= POWER_THR_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH_MIN: width_min <= cfg_data[LEN_W-1:0];
        REG_WIDTH_MAX: width_max <= cfg_data[LEN_W-1:0];
        REG_POWER_THR: power_thr <= cfg_data[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // classify the incoming sample
  assign neg  = sample_in[SAMPLE_W-1];
  assign pos  = !neg && (sample_in != '0);
  assign sx   = {sample_in[SAMPLE_W-1], sample_in};
  assign mag  = neg ? (~sx + MAG_W'(1)) : sx;
  assign flip = (pos && !pol_up) || (neg && pol_up);
  assign emit = flip && (len != '0);

  // a flip needs the other bank, which the back end may still be reading
  assign in_stall = emit && !bank_free;
  assign take     = in_valid && !in_stall;

  // gate decision for the arch that is closing
  assign keep = (len > width_min) && (len < width_max) && (sum > power_thr);

  assign push      = take && emit;
  assign push_desc = '{bank: bank, len: len, keep: keep};

  // new sample starts from an empty arch on a flip
  assign base_len = flip ? '0 : len;
  assign base_sum = flip ? '0 : sum;
  assign room     = base_len < MAX_LEN;
  assign wr_bank  = emit ? ~bank : bank;

  assign wr_en   = take && room;
  assign wr_addr = {wr_bank, base_len[IDX_W-1:0]};
  assign wr_data = sample_in;

  // saturating length and sum
  assign len_next = room ? (base_len + LEN_W'(1)) : base_len;
  assign sum_wide = {1'b0, base_sum} + (SUM_W+1)'(mag);
  assign sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

  // arch state
  always_ff @(posedge clk) begin
    if (rst) begin
      len    <= '0;
      sum    <= '0;
      pol_up <= 1'b0;
      bank   <= 1'b0;
    end else if (take) begin
      len  <= len_next;
      sum  <= sum_next;
      bank <= wr_bank;
      if (pos) begin
        pol_up <= 1'b1;
      end else if (neg) begin
        pol_up <= 1'b0;
      end
    end
  end

endmodule

FILE: design/hwag_desc_queue.sv
// single-entry queue of finished arch descriptors between front and back
module hwag_desc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hwag_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            q_valid,
  output hwag_pkg::desc_t q_desc
);

  import hwag_pkg::*;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (push) begin
      q_valid <= 1'b1;
    end else if (pop) begin
      q_valid <= 1'b0;
    end
  end

  // descriptor payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_desc <= push_desc;
    end
  end

endmodule

FILE: design/hwag_back.sv
// back end: reads a finished arch out of the buffer and emits it sample by sample
module hwag_back #(
  parameter int MAX_ARCH = hwag_pkg::MAX_ARCH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  hwag_pkg::desc_t               q_desc,
  output logic                          pop,
  output logic                          busy,
  output logic                          rd_en,
  output logic [$clog2(MAX_ARCH):0]     rd_addr,
  input  logic [hwag_pkg::SAMPLE_W-1:0] rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hwag_pkg::SAMPLE_W-1:0] sample_out,
  output logic                          kept,
  output logic                          last
);

  import hwag_pkg::*;

  localparam int IDX_W = $clog2(MAX_ARCH);

  desc_t            cur;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_inc;
  logic             last_rd;
  logic             rd_full;
  logic             rd_keep;
  logic             rd_last;
  logic             out_free;
  logic             xfer;

  // read issue and transfer control
  assign out_free = !out_valid || !out_stall;
  assign xfer     = rd_full && out_free;
  assign rd_en    = busy && (!rd_full || xfer);
  assign rd_addr  = {cur.bank, cnt[IDX_W-1:0]};
  assign cnt_inc  = cnt + LEN_W'(1);
  assign last_rd  = cnt_inc == cur.len;
  assign pop      = !busy && q_valid;

  // arch read sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (pop) begin
      busy <= 1'b1;
    end else if (rd_en && last_rd) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_desc;
      cnt <= '0;
    end else if (rd_en) begin
      cnt <= cnt_inc;
    end
  end

  // ram read data occupancy, tags travel with it
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_full <= 1'b0;
    end else if (rd_en) begin
      rd_full <= 1'b1;
    end else if (xfer) begin
      rd_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_keep <= cur.keep;
      rd_last <= last_rd;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (xfer) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      sample_out <= rd_keep ? rd_data : '0;
      kept       <= rd_keep;
      last       <= rd_last;
    end
  end

endmodule

FILE: design/half_wave_arch_gate_core.sv
// top level of the half-wave arch gate
//
//   channel   signals                                   direction
//   in        in_valid, in_stall, sample_in             sample requests in
//   out       out_valid, out_stall, sample_out/kept/last  arch samples out
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register writes in
//
// A sample is taken when in_valid is high; only a polarity flip stalls, and only
// while the previous arch is still queued or being read from its buffer bank.
// An arch of n samples leaves at one sample per cycle while out_stall is low,
// limited by the buffer read port; first comes via queue, sequencer, ram, out reg.
// Reset clears arch length, sum, polarity, queue and output valid; the buffer
// itself is never cleared. A stalled output holds; reads wait behind it.
module half_wave_arch_gate_core #(
  parameter int MAX_ARCH = hwag_pkg::MAX_ARCH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hwag_pkg::SAMPLE_W-1:0]  sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hwag_pkg::SAMPLE_W-1:0]  sample_out,
  output logic                           kept,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hwag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwag_pkg::CFG_W-1:0]     cfg_data
);

  import hwag_pkg::*;

  localparam int IDX_W     = $clog2(MAX_ARCH);
  localparam int RAM_DEPTH = 2 * (1 << IDX_W);

  logic                wr_en;
  logic [IDX_W:0]      wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                rd_en;
  logic [IDX_W:0]      rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  logic                push;
  desc_t               push_desc;
  logic                pop;
  logic                q_valid;
  desc_t               q_desc;
  logic                busy;
  logic                bank_free;

  // the other bank is free once nothing is queued or being read
  assign bank_free = !q_valid && !busy;

  hwag_front #(
    .MAX_ARCH (MAX_ARCH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_in (sample_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bank_free (bank_free),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_desc (push_desc)
  );

  hwag_desc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_desc    (q_desc)
  );

  hwag_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hwag_back #(
    .MAX_ARCH (MAX_ARCH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_desc     (q_desc),
    .pop        (pop),
    .busy       (busy),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .kept       (kept),
    .last       (last)
  );

endmodule

FILE: sim/half_wave_arch_gate_core_test.sv
// testbench for the half-wave arch gate core: directed table, random arches, predictor check
module half_wave_arch_gate_core_test;
  import hwag_pkg::*;

  localparam int ARCH_DEPTH = MAX_ARCH_DEF;
  localparam int SUM_CEIL   = (1 << SUM_W) - 1;
  localparam int CYCLE_CAP  = 400000;
  localparam int SETTLE     = 12;

  // one emitted arch sample
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                kept;
    logic                last;
  } arch_sample_t;

  // directed stimulus row; typed rows carry their own expectation
  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic                typed;
    logic                has_res;
    arch_sample_t        res;
  } dir_row_t;

  localparam arch_sample_t NONE    = '0;
  localparam arch_sample_t DROP_ONE = '{smp: '0, kept: 1'b0, last: 1'b1};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  sample_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  sample_out;
  logic                 kept;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDTH_MIN;
  logic [CFG_W-1:0]     cfg_data = '0;

  // arch gate predictor state and registers
  logic [SAMPLE_W-1:0]  arch_buf [ARCH_DEPTH];
  int                   arch_len = 0;
  int                   arch_sum = 0;
  bit                   pol_up = 1'b0;
  logic [LEN_W-1:0]     gate_wmin = WIDTH_MIN_RST;
  logic [LEN_W-1:0]     gate_wmax = WIDTH_MAX_RST;
  logic [SUM_W-1:0]     gate_thr = POWER_THR_RST;

  arch_sample_t         pending_samples [$];
  int                   err_count = 0;
  int                   cycle_count = 0;
  int                   in_idle_pct = 0;
  int                   out_stall_pct = 0;

  // directed part under reset settings (min 4, max 65, threshold 128)
  dir_row_t dir_rows [24] = '{
    '{16'd100,    1'b1, 1'b0, NONE},      // first positive after reset, empty arch
    '{-16'sd100,  1'b1, 1'b1, DROP_ONE},  // single-sample arch is too narrow
    '{16'd0,      1'b1, 1'b0, NONE},      // zero joins the arch
    '{16'd0,      1'b1, 1'b0, NONE},
    '{16'd32767,  1'b0, 1'b0, NONE},      // positive extreme closes three samples
    '{16'd1,      1'b1, 1'b0, NONE},
    '{16'd2,      1'b1, 1'b0, NONE},
    '{16'd3,      1'b1, 1'b0, NONE},
    '{16'd4,      1'b1, 1'b0, NONE},
    '{16'h8000,   1'b0, 1'b0, NONE},      // negative extreme, five-sample arch kept
    '{-16'sd1,    1'b1, 1'b0, NONE},
    '{-16'sd2,    1'b1, 1'b0, NONE},
    '{-16'sd3,    1'b1, 1'b0, NONE},
    '{16'd20,     1'b0, 1'b0, NONE},      // length equal to min, dropped
    '{16'd20,     1'b1, 1'b0, NONE},
    '{16'd20,     1'b1, 1'b0, NONE},
    '{16'd20,     1'b1, 1'b0, NONE},
    '{16'd48,     1'b1, 1'b0, NONE},
    '{-16'sd25,   1'b0, 1'b0, NONE},      // sum equal to threshold, dropped
    '{-16'sd25,   1'b1, 1'b0, NONE},
    '{-16'sd25,   1'b1, 1'b0, NONE},
    '{-16'sd25,   1'b1, 1'b0, NONE},
    '{-16'sd29,   1'b1, 1'b0, NONE},
    '{16'd1,      1'b0, 1'b0, NONE}       // sum one above threshold, kept
  };

  half_wave_arch_gate_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .kept       (kept),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // compare each taken output request with the oldest expected sample
  always @(posedge clk) begin : check_out
    arch_sample_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        err_count++;
        $display("%0t unexpected output: sample_out %h kept %b last %b",
                 $time, sample_out, kept, last);
      end else begin
        want = pending_samples[0];
        pending_samples.delete(0);
        if (sample_out !== want.smp) begin
          err_count++;
          $display("%0t sample_out expected %h actual %h", $time, want.smp, sample_out);
        end
        if (kept !== want.kept) begin
          err_count++;
          $display("%0t kept expected %b actual %b", $time, want.kept, kept);
        end
        if (last !== want.last) begin
          err_count++;
          $display("%0t last expected %b actual %b", $time, want.last, last);
        end
      end
    end
  end

  // advance the predictor by one sample; a polarity flip emits the finished arch
  task automatic gate_arch_sample(input logic [SAMPLE_W-1:0] s, input bit push);
    bit neg;
    bit pos;
    bit keep;
    int mag;
    arch_sample_t res;
    neg = s[SAMPLE_W-1];
    pos = !neg && (s != '0);
    mag = neg ? 65536 - int'(s) : int'(s);
    if ((pos && !pol_up) || (neg && pol_up)) begin
      keep = (arch_len > gate_wmin) && (arch_len < gate_wmax) && (arch_sum > gate_thr);
      if (push) begin
        for (int i = 0; i < arch_len; i++) begin
          res.smp  = keep ? arch_buf[i] : '0;
          res.kept = keep;
          res.last = (i == arch_len - 1);
          pending_samples.insert(pending_samples.size(), res);
        end
      end
      arch_len = 0;
      arch_sum = 0;
    end
    if (pos) pol_up = 1'b1;
    else if (neg) pol_up = 1'b0;
    if (arch_len < ARCH_DEPTH) begin
      arch_buf[arch_len] = s;
      arch_len++;
    end
    arch_sum += mag;
    if (arch_sum > SUM_CEIL) arch_sum = SUM_CEIL;
  endtask

  // drive one sample request, wait until taken, then maybe leave a gap
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit push);
    int gap;
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (in_stall);
    gate_arch_sample(s, push);
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold input until every expected sample is out, then let the pipe settle
  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // register write request
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH_MIN: gate_wmin = val[LEN_W-1:0];
      REG_WIDTH_MAX: gate_wmax = val[LEN_W-1:0];
      REG_POWER_THR: gate_thr = val[SUM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // new settings once idle; width registers get junk in unused upper bits
  task automatic set_phase(input logic [LEN_W-1:0] wmin, input logic [LEN_W-1:0] wmax,
                           input logic [SUM_W-1:0] thr, input int in_pct, input int out_pct);
    drain_outputs();
    write_reg(REG_WIDTH_MIN, {15'($urandom), wmin});
    write_reg(REG_WIDTH_MAX, {15'($urandom), wmax});
    write_reg(REG_POWER_THR, thr);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  // random arches of alternating polarity, some noise, rare long ones
  task automatic run_random(input int n_items, input bit pressure);
    int sent;
    int len;
    int r;
    int mag;
    bit up;
    bit noise;
    bit paused;
    logic [SAMPLE_W-1:0] s;
    sent   = 0;
    paused = 1'b0;
    up     = !pol_up;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 40);
      else len = $urandom_range(60, 70);
      noise = ($urandom_range(0, 99) < 15);
      for (int i = 0; i < len; i++) begin
        if (noise) begin
          s = 16'($urandom);
        end else if (i != 0 && $urandom_range(0, 9) == 0) begin
          s = '0;
        end else begin
          case ($urandom_range(0, 3))
            0: mag = $urandom_range(1, 64);
            1: mag = $urandom_range(1, 1000);
            2: mag = $urandom_range(1, 32767);
            default: mag = up ? 32767 : 32768;
          endcase
          s = up ? 16'(mag) : 16'(-mag);
        end
        send_sample(s, 1'b1);
      end
      sent += len;
      up = ~up;
      // sender holds off once until the output side has caught up
      if (pressure && !paused && sent >= n_items / 2) begin
        paused = 1'b1;
        drain_outputs();
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed rows under reset settings
    for (int k = 0; k < $size(dir_rows); k++) begin
      if (dir_rows[k].typed && dir_rows[k].has_res)
        pending_samples.insert(pending_samples.size(), dir_rows[k].res);
      send_sample(dir_rows[k].smp, !dir_rows[k].typed);
    end

    set_phase(7'd4, 7'd65, 22'd128, 0, 0);
    run_random(6, 1'b0);
    set_phase(7'd0, 7'd65, 22'd0, 72, 0);
    run_random(6, 1'b0);
    set_phase(7'd64, 7'd65, 22'd0, 0, 72);
    run_random(6, 1'b0);
    set_phase(7'd0, 7'd1, 22'd2097152, 35, 35);
    run_random(6, 1'b0);

    // arch past the buffer depth with a saturated sum, kept only if the sum clips
    set_phase(7'd63, 7'd127, 22'd4194302, 0, 0);
    send_sample(16'd1, 1'b1);
    repeat (130) send_sample(16'h8000, 1'b1);
    send_sample(16'd1, 1'b1);
    run_random(6, 1'b0);

    set_phase(7'd2, 7'd10, 22'd1000, 35, 35);
    run_random(6, 1'b1);
    set_phase(7'd1, 7'd64, 22'd200, 72, 72);
    run_random(6, 1'b0);

    drain_outputs();
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
